// ===== rtl/tcce_pkg.sv =====
// Shared constants for the text console character engine.
package tcce_pkg;

  localparam int DEF_ROWS = 25;
  localparam int DEF_COLS = 80;

  localparam int ROW_FW  = 5;
  localparam int COL_FW  = 7;
  localparam int CHAR_FW = 8;
  localparam int COLR_FW = 4;
  localparam int STAT_FW = 2;
  localparam int CELL_W  = CHAR_FW + 2 * COLR_FW;
  localparam int TYPED_W = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CHAR_FW-1:0] CH_LEFT    = 8'hF0;
  localparam logic [CHAR_FW-1:0] CH_RIGHT   = 8'hF1;
  localparam logic [CHAR_FW-1:0] CH_UP      = 8'hF2;
  localparam logic [CHAR_FW-1:0] CH_DOWN    = 8'hF3;
  localparam logic [CHAR_FW-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_FW-1:0] CH_DEL     = 8'h7F;
  localparam logic [CHAR_FW-1:0] CH_NL      = 8'h0A;
  localparam logic [CHAR_FW-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_FW-1:0] CH_TILDE   = 8'h7E;

  localparam logic [STAT_FW-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_FW-1:0] STAT_TOP      = 2'd1;
  localparam logic [STAT_FW-1:0] STAT_BOTTOM   = 2'd2;

  localparam logic [COLR_FW-1:0] RST_BLANK_BG = 4'd0;
  localparam logic [COLR_FW-1:0] RST_BLANK_FG = 4'd15;

  localparam logic REG_BLANK_BG = 1'b0;
  localparam logic REG_BLANK_FG = 1'b1;

endpackage

// ===== rtl/tcce_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/text_console_char_engine_top.sv =====
// Top level of the text console character engine: cursor control and cell memory sequencer.
//
//  channel   | ports                                  | transfer
//  ----------+----------------------------------------+-------------------------------------
//  input     | start, busy, in_*                      | edge with start high and busy low
//  result    | out_valid, out_*                       | one cycle strobe, cannot be held off
//  config    | psel, penable, pwrite, paddr, pwdata,  | access phase, pready always high
//            | prdata, pready                         |
//
// Cursor moves, newline, printable characters without a scroll and reads outside the screen
// complete straight from the idle state; a read inside the screen passes through ST_RDOUT for
// the registered RAM read. Backspace and scroll pass through ST_MOVE and ST_FILL: the single
// RAM write port moves one cell per cycle, with the read of the next cell overlapping the write.
// After reset the engine clears all ROWS*COLS cells, one per cycle, with busy held high;
// configuration writes are taken during that pass. Results are never stalled.
module text_console_char_engine_top #(
  parameter int SCREEN_ROWS = tcce_pkg::DEF_ROWS,
  parameter int SCREEN_COLS = tcce_pkg::DEF_COLS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [tcce_pkg::CHAR_FW-1:0]   in_char_code,
  input  logic [tcce_pkg::COLR_FW-1:0]   in_back_color,
  input  logic [tcce_pkg::COLR_FW-1:0]   in_fore_color,
  input  logic [tcce_pkg::ROW_FW-1:0]    in_read_row,
  input  logic [tcce_pkg::COL_FW-1:0]    in_read_col,
  output logic                           out_valid,
  output logic [tcce_pkg::STAT_FW-1:0]   out_status,
  output logic [tcce_pkg::ROW_FW-1:0]    out_cur_row,
  output logic [tcce_pkg::COL_FW-1:0]    out_cur_col,
  output logic [tcce_pkg::CHAR_FW-1:0]   out_cell_char,
  output logic [tcce_pkg::COLR_FW-1:0]   out_cell_bg,
  output logic [tcce_pkg::COLR_FW-1:0]   out_cell_fg,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcce_pkg::APB_AW-1:0]    paddr,
  input  logic [tcce_pkg::APB_DW-1:0]    pwdata,
  output logic [tcce_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  import tcce_pkg::*;

  localparam int NCELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int CNTW   = $clog2(NCELLS + 1);
  localparam int RW     = $clog2(SCREEN_ROWS);
  localparam int CW     = $clog2(SCREEN_COLS);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RDOUT = 2'd1;
  localparam logic [1:0] ST_MOVE  = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [TYPED_W-1:0]  typed_r, typed_nxt;
  logic [COLR_FW-1:0]  blank_bg_r, blank_fg_r;
  logic [AW-1:0]       mv_rd_r, mv_rd_nxt;
  logic [AW-1:0]       mv_wr_r, mv_wr_nxt;
  logic [AW-1:0]       mv_left_r, mv_left_nxt;
  logic                mv_pend_r, mv_pend_nxt;
  logic [CNTW-1:0]     fill_left_r, fill_left_nxt;
  logic                recolor_r, recolor_nxt;
  logic [COLR_FW-1:0]  rc_bg_r, rc_bg_nxt;
  logic [COLR_FW-1:0]  rc_fg_r, rc_fg_nxt;
  logic [CELL_W-1:0]   fill_cell_r, fill_cell_nxt;
  logic                emit_r, emit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_FW-1:0]  out_status_r, out_status_nxt;
  logic [CELL_W-1:0]   out_cell_r, out_cell_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic                accept;
  logic                last_row, last_col, at_first;
  logic                rd_in_range;
  logic [AW-1:0]       cur_addr, bs_addr;
  logic [RW-1:0]       sb_row, bs_row;
  logic [CW-1:0]       sb_col, bs_col;
  logic                cfg_wr;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign last_row = (row_r == RW'(SCREEN_ROWS - 1));
  assign last_col = (col_r == CW'(SCREEN_COLS - 1));
  assign at_first = (col_r == '0);
  assign cur_addr = AW'(row_r) * AW'(SCREEN_COLS) + AW'(col_r);

  // Step back one cell: from column 0 go to the end of the row above, or of the top row when already on it.
  always_comb begin
    if (!at_first) begin
      sb_row = row_r;
      sb_col = col_r - CW'(1);
    end else begin
      sb_row = (row_r != '0) ? row_r - RW'(1) : row_r;
      sb_col = CW'(SCREEN_COLS - 1);
    end
  end

  assign bs_row  = (typed_r != '0) ? sb_row : row_r;
  assign bs_col  = (typed_r != '0) ? sb_col : col_r;
  assign bs_addr = AW'(bs_row) * AW'(SCREEN_COLS) + AW'(bs_col);

  assign rd_in_range = (int'(in_read_row) < SCREEN_ROWS) && (int'(in_read_col) < SCREEN_COLS);

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    typed_nxt      = typed_r;
    mv_rd_nxt      = mv_rd_r;
    mv_wr_nxt      = mv_wr_r;
    mv_left_nxt    = mv_left_r;
    mv_pend_nxt    = 1'b0;
    fill_left_nxt  = fill_left_r;
    recolor_nxt    = recolor_r;
    rc_bg_nxt      = rc_bg_r;
    rc_fg_nxt      = rc_fg_r;
    fill_cell_nxt  = fill_cell_r;
    emit_nxt       = emit_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_cell_nxt   = out_cell_r;
    ram_we         = 1'b0;
    ram_waddr      = mv_wr_r;
    ram_wdata      = fill_cell_r;
    ram_raddr      = AW'(in_read_row) * AW'(SCREEN_COLS) + AW'(in_read_col);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_status_nxt = STAT_OK;
          out_cell_nxt   = '0;
          if (in_func) begin
            if (rd_in_range) begin
              state_nxt = ST_RDOUT;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else begin
            // By default the item completes now; scrolls and backspace go to the sequencer.
            out_valid_nxt = 1'b1;
            case (in_char_code)
              CH_LEFT: begin
                if (typed_r != '0) begin
                  row_nxt = sb_row;
                  col_nxt = sb_col;
                end
              end
              CH_UP: begin
                if (row_r == '0) begin
                  out_status_nxt = STAT_TOP;
                end else begin
                  row_nxt = row_r - RW'(1);
                end
              end
              CH_DOWN: begin
                if (last_row) begin
                  out_status_nxt = STAT_BOTTOM;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end
              CH_BS, CH_DEL: begin
                if (typed_r != '0) begin
                  typed_nxt = typed_r - TYPED_W'(1);
                end
                row_nxt       = bs_row;
                col_nxt       = bs_col;
                mv_wr_nxt     = bs_addr;
                mv_rd_nxt     = bs_addr + AW'(1);
                mv_left_nxt   = AW'(SCREEN_COLS - 1) - AW'(bs_col);
                recolor_nxt   = 1'b1;
                rc_bg_nxt     = in_back_color;
                rc_fg_nxt     = in_fore_color;
                fill_left_nxt = CNTW'(1);
                fill_cell_nxt = {CH_SPACE, in_back_color, in_fore_color};
                emit_nxt      = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_MOVE;
              end
              default: begin
                if (in_char_code inside {[CH_SPACE:CH_TILDE]} || in_char_code == CH_RIGHT ||
                    in_char_code == CH_NL) begin
                  if (in_char_code inside {[CH_SPACE:CH_TILDE]}) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_addr;
                    ram_wdata = {in_char_code, in_back_color, in_fore_color};
                    if (typed_r != {TYPED_W{1'b1}}) begin
                      typed_nxt = typed_r + TYPED_W'(1);
                    end
                  end
                  if (in_char_code != CH_NL && !last_col) begin
                    col_nxt = col_r + CW'(1);
                  end else begin
                    col_nxt = '0;
                    if (!last_row) begin
                      row_nxt = row_r + RW'(1);
                    end else begin
                      // Past the bottom row: move every row up and blank the last one.
                      mv_rd_nxt     = AW'(SCREEN_COLS);
                      mv_wr_nxt     = '0;
                      mv_left_nxt   = AW'(NCELLS - SCREEN_COLS);
                      recolor_nxt   = 1'b0;
                      fill_left_nxt = CNTW'(SCREEN_COLS);
                      fill_cell_nxt = {CH_SPACE, blank_bg_r, blank_fg_r};
                      emit_nxt      = 1'b1;
                      out_valid_nxt = 1'b0;
                      state_nxt     = ST_MOVE;
                    end
                  end
                end
              end
            endcase
          end
        end
      end
      ST_RDOUT: begin
        out_cell_nxt  = ram_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_MOVE: begin
        // Reads run one cell ahead of writes; the source is always at a higher address than the destination.
        ram_raddr = mv_rd_r;
        if (mv_left_r != '0) begin
          mv_rd_nxt   = mv_rd_r + AW'(1);
          mv_left_nxt = mv_left_r - AW'(1);
          mv_pend_nxt = 1'b1;
        end
        if (mv_pend_r) begin
          ram_we    = 1'b1;
          ram_wdata = recolor_r ? {ram_rdata[CELL_W-1 -: CHAR_FW], rc_bg_r, rc_fg_r}
                                : ram_rdata;
          mv_wr_nxt = mv_wr_r + AW'(1);
        end
        if (mv_left_r == '0 && !mv_pend_r) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        ram_we        = 1'b1;
        mv_wr_nxt     = mv_wr_r + AW'(1);
        fill_left_nxt = fill_left_r - CNTW'(1);
        if (fill_left_r == CNTW'(1)) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = emit_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      row_r        <= '0;
      col_r        <= '0;
      typed_r      <= '0;
      mv_rd_r      <= '0;
      mv_wr_r      <= '0;
      mv_left_r    <= '0;
      mv_pend_r    <= 1'b0;
      fill_left_r  <= CNTW'(NCELLS);
      recolor_r    <= 1'b0;
      fill_cell_r  <= {CH_SPACE, RST_BLANK_BG, RST_BLANK_FG};
      emit_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= STAT_OK;
      out_cell_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      typed_r      <= typed_nxt;
      mv_rd_r      <= mv_rd_nxt;
      mv_wr_r      <= mv_wr_nxt;
      mv_left_r    <= mv_left_nxt;
      mv_pend_r    <= mv_pend_nxt;
      fill_left_r  <= fill_left_nxt;
      recolor_r    <= recolor_nxt;
      fill_cell_r  <= fill_cell_nxt;
      emit_r       <= emit_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_cell_r   <= out_cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rc_bg_r <= rc_bg_nxt;
    rc_fg_r <= rc_fg_nxt;
  end

  // Configuration registers; only bit 2 of the address selects between them.
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_bg_r <= RST_BLANK_BG;
      blank_fg_r <= RST_BLANK_FG;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BLANK_BG) begin
        blank_bg_r <= pwdata[COLR_FW-1:0];
      end else begin
        blank_fg_r <= pwdata[COLR_FW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_BLANK_BG) ? APB_DW'(blank_bg_r) : APB_DW'(blank_fg_r);
  assign pready = 1'b1;

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_cur_row   = ROW_FW'(row_r);
  assign out_cur_col   = COL_FW'(col_r);
  assign out_cell_char = out_cell_r[CELL_W-1 -: CHAR_FW];
  assign out_cell_bg   = out_cell_r[2*COLR_FW-1 -: COLR_FW];
  assign out_cell_fg   = out_cell_r[COLR_FW-1:0];

endmodule

// ===== rtl/tcce_checker.sv =====
// Port-level assertion checker for the text console character engine, with its bind.
module tcce_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [tcce_pkg::STAT_FW-1:0]   out_status,
  input logic [tcce_pkg::ROW_FW-1:0]    out_cur_row
);

  import tcce_pkg::*;

  a_item_progresses: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted item neither completed nor started work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_TOP ||
                   out_status == STAT_BOTTOM))
    else $error("undefined status code");

  a_top_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_TOP) |-> (out_cur_row == '0))
    else $error("up blocked while cursor not on the top row");

  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && busy) |-> $past(start) && !$past(busy))
    else $error("result strobe during a long operation");

endmodule

bind text_console_char_engine_top tcce_checker u_tcce_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_cur_row (out_cur_row)
);
